// File: rtl/spv_pkg.sv
// Shared constants, codes and types of the slave poll supervisor.
`timescale 1ns / 1ps
`default_nettype none

package spv_pkg;

  localparam int MAX_BOARDS = 32;
  localparam int MASK_W     = 32;
  localparam int BOARD_SPAN = (MAX_BOARDS < MASK_W) ? MAX_BOARDS : MASK_W;
  localparam int IDX_W      = $clog2(MAX_BOARDS);
  localparam int POS_W      = $clog2(BOARD_SPAN);
  localparam int CNT_W      = $clog2(BOARD_SPAN + 1);
  localparam int BOARD_W    = 6;
  localparam int MISS_W     = 3;
  localparam int OPC_W      = 2;
  localparam int SRC_W      = 8;
  localparam int TYPE_W     = 8;
  localparam int PRIO_W     = 4;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [MISS_W-1:0] FAULT_LIMIT = MISS_W'(6);
  localparam logic [MASK_W-1:0] SPAN_MASK   = {MASK_W{1'b1}} >> (MASK_W - BOARD_SPAN);

  typedef enum logic [OPC_W-1:0] {
    OP_POLL    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_FRAME   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_MASK         = 2'd0,
    REG_NORMAL_TYPE  = 2'd1,
    REG_CONFIRM_TYPE = 2'd2,
    REG_PRIORITY     = 2'd3
  } reg_idx_t;

  typedef logic [BOARD_W-1:0] board_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [MISS_W-1:0]  miss_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    cnt_t              count;
  } list_info_t;

  typedef struct packed {
    logic   poll_valid;
    board_t poll_board;
    logic   fault_raised;
    logic   recovered;
    logic   send_ack;
    logic   info_valid;
    logic   confirm_seen;
    board_t event_board;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/slave_poll_supervisor.sv
// Top level of the slave poll supervisor: round-robin poller with per-board miss counts.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake           Carries
// in_*       in         in_valid/in_ready   one event request: opcode, source, type, priority
// out_*      out        out_valid/out_ready one result request per event
// APB        in/out     psel/penable        mask, reply type, confirm type, reply priority
//
// One event per cycle sustained while out_ready is high; a result is presented from the output
// register (the miss-count memory is read as the event is taken, the result is then registered).
// Miss counts live in a 32 x 3 synchronous memory; a flop valid bit per board makes an
// unwritten entry read as zero, so reset is immediate and needs no clearing pass.
// Back-to-back hits on one board are served from the last-write register.
// out_ready low holds the pipeline; in_ready drops only while both stages are full.

module slave_poll_supervisor (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire logic [spv_pkg::OPC_W-1:0]   in_opcode,
  input  wire logic [spv_pkg::SRC_W-1:0]   in_source_board,
  input  wire logic [spv_pkg::TYPE_W-1:0]  in_frame_type,
  input  wire logic [spv_pkg::PRIO_W-1:0]  in_frame_priority,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_poll_valid,
  output logic [spv_pkg::BOARD_W-1:0]    out_poll_board,
  output logic                           out_fault_raised,
  output logic                           out_recovered,
  output logic                           out_send_ack,
  output logic                           out_info_valid,
  output logic                           out_confirm_seen,
  output logic [spv_pkg::BOARD_W-1:0]    out_event_board,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire logic [spv_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [spv_pkg::DATA_W-1:0]  pwdata,
  output logic [spv_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import spv_pkg::*;

  // ---------------------------------------------------------------- configuration
  logic [TYPE_W-1:0] normal_type_r;
  logic [TYPE_W-1:0] confirm_type_r;
  logic [PRIO_W-1:0] reply_prio_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  list_info_t        list_info;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_type_r  <= '0;
      confirm_type_r <= '0;
      reply_prio_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MASK:         ;
        REG_NORMAL_TYPE:  normal_type_r  <= pwdata[TYPE_W-1:0];
        REG_CONFIRM_TYPE: confirm_type_r <= pwdata[TYPE_W-1:0];
        REG_PRIORITY:     reply_prio_r   <= pwdata[PRIO_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MASK:         prdata = list_info.mask;
      REG_NORMAL_TYPE:  prdata = DATA_W'(normal_type_r);
      REG_CONFIRM_TYPE: prdata = DATA_W'(confirm_type_r);
      REG_PRIORITY:     prdata = DATA_W'(reply_prio_r);
    endcase
  end

  // ---------------------------------------------------------------- declarations
  pos_t             pos_r;
  pos_t             idle_pos;
  board_t           idle_cur;
  cnt_t             pos_inc;
  pos_t             s1_adv_pos;
  board_t           s1_nxt;
  logic             s1_adv;
  pos_t             s1_pos_out;
  board_t           s1_cur_out;

  logic             s1_v_r;
  opcode_t          s1_op_r;
  logic             s1_reg_r;
  logic [IDX_W-1:0] s1_addr_r;
  board_t           s1_cur_r;
  pos_t             s1_pos_r;
  board_t           s1_src_r;
  logic             s1_norm_r;
  logic             s1_conf_r;
  logic             s1_src_cur_r;
  logic             s1_move;
  logic             in_acc;

  opcode_t          s0_op;
  pos_t             s0_pos;
  board_t           s0_cur;
  board_t           s0_cur_m1;
  logic [SRC_W-1:0] s0_src_m1;
  logic             s0_reg;
  logic [IDX_W-1:0] s0_addr;

  miss_t            miss_mem [MAX_BOARDS];
  miss_t            mem_rdata_r;
  logic [MAX_BOARDS-1:0] miss_vld_r;
  logic             lw_v_r;
  logic [IDX_W-1:0] lw_addr_r;
  miss_t            lw_data_r;
  miss_t            miss_cur;
  logic [MISS_W:0]  miss_inc;
  logic             over_limit;
  logic             has_cur;
  logic             do_poll;
  logic             do_frame;
  logic             wr_en;
  miss_t            wr_data;

  result_t          res_nxt;
  result_t          res_r;
  logic             out_v_r;

  // ---------------------------------------------------------------- board list
  // Position as seen with an empty pipeline: drop back to the first board
  // when the list has shrunk under it.
  assign idle_pos = (CNT_W'(pos_r) >= list_info.count) ? '0 : pos_r;

  spv_board_list u_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr && cfg_idx == REG_MASK),
    .wr_data (pwdata),
    .idx_a   (idle_pos),
    .idx_b   (s1_adv_pos),
    .info    (list_info),
    .board_a (idle_cur),
    .board_b (s1_nxt)
  );

  // ---------------------------------------------------------------- handshakes
  assign s1_move  = !out_v_r || out_ready;
  assign in_ready = s1_move || !s1_v_r;
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------- stage 0: address
  // The item in stage 1 may move the pointer; take its outcome directly so
  // that the next event sees the right current board.
  assign s0_op     = opcode_t'(in_opcode);
  assign s0_pos    = s1_v_r ? s1_pos_out : idle_pos;
  assign s0_cur    = s1_v_r ? s1_cur_out : idle_cur;
  assign s0_cur_m1 = s0_cur - BOARD_W'(1);
  assign s0_src_m1 = in_source_board - SRC_W'(1);
  assign s0_reg    = (in_source_board != '0) && (in_source_board <= SRC_W'(BOARD_SPAN))
                     && list_info.mask[s0_src_m1[POS_W-1:0]];
  assign s0_addr   = (s0_op == OP_FRAME) ? s0_src_m1[IDX_W-1:0] : s0_cur_m1[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r      <= s0_op;
      s1_reg_r     <= s0_reg;
      s1_addr_r    <= s0_addr;
      s1_cur_r     <= s0_cur;
      s1_pos_r     <= s0_pos;
      s1_src_r     <= in_source_board[BOARD_W-1:0];
      s1_norm_r    <= (in_frame_type == normal_type_r) && (in_frame_priority == reply_prio_r);
      s1_conf_r    <= (in_frame_type == confirm_type_r) && (in_frame_priority == reply_prio_r);
      s1_src_cur_r <= (SRC_W'(s0_cur) == in_source_board);
    end
  end

  // ---------------------------------------------------------------- miss-count memory
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_rdata_r <= miss_mem[s0_addr];
    end
    if (wr_en) begin
      miss_mem[s1_addr_r] <= wr_data;
    end
  end

  // valid bits and last-write register for same-entry forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_vld_r <= '0;
      lw_v_r     <= 1'b0;
    end else if (wr_en) begin
      miss_vld_r[s1_addr_r] <= 1'b1;
      lw_v_r                <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= s1_addr_r;
      lw_data_r <= wr_data;
    end
  end

  // ---------------------------------------------------------------- stage 1: modify
  always_comb begin
    if (lw_v_r && lw_addr_r == s1_addr_r) begin
      miss_cur = lw_data_r;
    end else if (miss_vld_r[s1_addr_r]) begin
      miss_cur = mem_rdata_r;
    end else begin
      miss_cur = '0;
    end
  end

  assign pos_inc    = CNT_W'(s1_pos_r) + CNT_W'(1);
  assign s1_adv_pos = (pos_inc < list_info.count) ? pos_t'(pos_inc) : '0;

  assign has_cur    = (s1_cur_r != '0);
  assign miss_inc   = {1'b0, miss_cur} + (MISS_W + 1)'(1);
  assign over_limit = miss_inc > {1'b0, FAULT_LIMIT};
  assign do_poll    = (s1_op_r == OP_POLL) && has_cur;
  assign do_frame   = (s1_op_r == OP_FRAME) && s1_reg_r;

  // Timeout holds the board while the count is below the limit and odd;
  // a normal reply from the current board moves on.
  assign s1_adv = ((s1_op_r == OP_TIMEOUT) && has_cur
                   && !(miss_cur < FAULT_LIMIT && miss_cur[0]))
                  || (do_frame && s1_norm_r && s1_src_cur_r);

  assign s1_pos_out = s1_adv ? s1_adv_pos : s1_pos_r;
  assign s1_cur_out = s1_adv ? s1_nxt : s1_cur_r;

  // saturate on a poll, clear on any frame from a registered board
  assign wr_en   = s1_v_r && s1_move && (do_poll || do_frame);
  assign wr_data = do_poll ? (over_limit ? FAULT_LIMIT : miss_inc[MISS_W-1:0]) : '0;

  always_comb begin
    res_nxt              = '0;
    res_nxt.poll_valid   = do_poll;
    res_nxt.poll_board   = do_poll ? s1_cur_r : '0;
    res_nxt.fault_raised = do_poll && over_limit;
    res_nxt.recovered    = do_frame && (miss_cur >= FAULT_LIMIT);
    res_nxt.confirm_seen = do_frame && !s1_norm_r && s1_conf_r;
    res_nxt.send_ack     = do_frame && !s1_norm_r && !s1_conf_r;
    res_nxt.info_valid   = do_frame && !s1_norm_r && !s1_conf_r;
    if (res_nxt.fault_raised) begin
      res_nxt.event_board = s1_cur_r;
    end else if (res_nxt.recovered || res_nxt.confirm_seen || res_nxt.send_ack) begin
      res_nxt.event_board = s1_src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (s1_v_r && s1_move) begin
      pos_r <= s1_pos_out;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_poll_valid   = res_r.poll_valid;
  assign out_poll_board   = res_r.poll_board;
  assign out_fault_raised = res_r.fault_raised;
  assign out_recovered    = res_r.recovered;
  assign out_send_ack     = res_r.send_ack;
  assign out_info_valid   = res_r.info_valid;
  assign out_confirm_seen = res_r.confirm_seen;
  assign out_event_board  = res_r.event_board;

  // ---------------------------------------------------------------- assertions
  a_fault_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault_raised |-> out_poll_valid && out_event_board == out_poll_board)
    else $error("fault raised without a poll to the same board");

  a_event_board: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_board != '0) ==
                   (out_fault_raised || out_recovered || out_confirm_seen || out_info_valid)))
    else $error("event board does not match the event flags");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> wr_data <= FAULT_LIMIT)
    else $error("miss count written above the fault limit");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_move |=> s1_v_r && $stable(s1_addr_r) && $stable(mem_rdata_r))
    else $error("stalled request lost its memory read");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_move && list_info.count != '0 |=> CNT_W'(pos_r) < list_info.count)
    else $error("poll position left the board list");

endmodule

`default_nettype wire

// File: rtl/spv_board_list.sv
// Registered board mask with prefix counts and two list-position lookups.
`timescale 1ns / 1ps
`default_nettype none

module spv_board_list (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         wr_en,
  input  wire logic [spv_pkg::MASK_W-1:0] wr_data,
  input  wire spv_pkg::pos_t          idx_a,
  input  wire spv_pkg::pos_t          idx_b,
  output spv_pkg::list_info_t         info,
  output spv_pkg::board_t             board_a,
  output spv_pkg::board_t             board_b
);
  import spv_pkg::*;

  logic [MASK_W-1:0] mask_r;
  cnt_t              count_r;
  cnt_t              prefix_r   [BOARD_SPAN];
  cnt_t              prefix_nxt [BOARD_SPAN];

  // number of registered boards below each board position
  always_comb begin
    for (int k = 0; k < BOARD_SPAN; k++) begin
      prefix_nxt[k] = CNT_W'($countones(wr_data & ((MASK_W'(1) << k) - MASK_W'(1))));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      count_r <= '0;
      for (int k = 0; k < BOARD_SPAN; k++) begin
        prefix_r[k] <= '0;
      end
    end else if (wr_en) begin
      mask_r  <= wr_data;
      count_r <= CNT_W'($countones(wr_data & SPAN_MASK));
      for (int k = 0; k < BOARD_SPAN; k++) begin
        prefix_r[k] <= prefix_nxt[k];
      end
    end
  end

  // the board whose prefix count equals the position is the one selected
  always_comb begin
    board_a = '0;
    board_b = '0;
    for (int k = 0; k < BOARD_SPAN; k++) begin
      if (mask_r[k] && prefix_r[k] == CNT_W'(idx_a)) begin
        board_a = board_a | BOARD_W'(k + 1);
      end
      if (mask_r[k] && prefix_r[k] == CNT_W'(idx_b)) begin
        board_b = board_b | BOARD_W'(k + 1);
      end
    end
  end

  assign info.mask  = mask_r;
  assign info.count = count_r;

endmodule

`default_nettype wire
